// ----- sv/mlrd_pkg.sv -----
// ----------------------------------------------------------------------------
// mlrd_pkg
// Shared types and constants of the magic-word length-prefixed record deframer.
// ----------------------------------------------------------------------------
package mlrd_pkg;

	localparam int unsigned LEN_W = 26;
	localparam int unsigned MAGIC_W = 32;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned ADDR_W = 3;

	localparam logic [31:0] MIN_RECORD_LENGTH = 32'd80;
	localparam logic [MAGIC_W-1:0] MAGIC_RESET = 32'hF9BEB4D9;
	localparam logic [LEN_W-1:0] MAX_LEN_RESET = 26'd4000000;

	// register index, taken from paddr bit 2
	localparam logic REG_MAGIC_WORD = 1'b0;
	localparam logic REG_MAX_LENGTH = 1'b1;

	typedef struct packed {
		logic [BYTE_W-1:0] payload_byte;
		logic first_of_record;
		logic last_of_record;
		logic [LEN_W-1:0] record_length;
	} result_t;

endpackage

// ----- sv/mlrd_core.sv -----
// ----------------------------------------------------------------------------
// mlrd_core
// Header search window, length check and payload counting, one beat a cycle while beat_accept is high.
// ----------------------------------------------------------------------------
module mlrd_core (
	input  logic clk,
	input  logic arst_n,
	input  logic beat_accept,
	input  logic [mlrd_pkg::BYTE_W-1:0] data_byte,
	input  logic file_start,
	input  logic [mlrd_pkg::MAGIC_W-1:0] magic_word,
	input  logic [mlrd_pkg::LEN_W-1:0] max_record_length,
	output logic res_push,
	output mlrd_pkg::result_t result
);

	logic [63:0] window_q;
	logic [3:0] fill_q;
	logic in_payload_q;
	logic [mlrd_pkg::LEN_W-1:0] bytes_left_q;
	logic [mlrd_pkg::LEN_W-1:0] cur_len_q;

	logic [63:0] window_d;
	logic [3:0] fill_d;
	logic in_payload_d;
	logic [mlrd_pkg::LEN_W-1:0] bytes_left_d;
	logic [mlrd_pkg::LEN_W-1:0] cur_len_d;

	logic eff_payload;
	logic [mlrd_pkg::LEN_W-1:0] eff_left;
	logic [mlrd_pkg::LEN_W-1:0] eff_len;
	logic [63:0] shifted;
	logic [3:0] fill_inc;
	logic [31:0] hdr_len;
	logic hit;
	logic is_first;
	logic is_last;

	always_comb begin
		// a new file abandons whatever was going on
		eff_payload = in_payload_q & ~file_start;
		eff_left = file_start ? '0 : bytes_left_q;
		eff_len = file_start ? '0 : cur_len_q;

		shifted = file_start ? {56'd0, data_byte} : {window_q[55:0], data_byte};
		if (file_start) begin
			fill_inc = 4'd1;
		end else if (fill_q < 4'd8) begin
			fill_inc = fill_q + 4'd1;
		end else begin
			fill_inc = fill_q;
		end

		// length is little endian in the newest four bytes
		hdr_len = {shifted[7:0], shifted[15:8], shifted[23:16], shifted[31:24]};
		hit = (fill_inc >= 4'd8) && (shifted[63:32] == magic_word)
			&& (hdr_len >= mlrd_pkg::MIN_RECORD_LENGTH)
			&& (hdr_len <= {6'd0, max_record_length});

		is_first = (eff_left == eff_len);
		is_last = (eff_left <= 26'd1);

		window_d = window_q;
		fill_d = fill_q;
		in_payload_d = eff_payload;
		bytes_left_d = eff_left;
		cur_len_d = eff_len;
		if (file_start) begin
			window_d = '0;
			fill_d = '0;
		end

		if (eff_payload) begin
			if (is_last) begin
				in_payload_d = 1'b0;
				bytes_left_d = '0;
				window_d = '0;
				fill_d = '0;
			end else begin
				bytes_left_d = eff_left - 26'd1;
			end
		end else if (hit) begin
			in_payload_d = 1'b1;
			cur_len_d = hdr_len[mlrd_pkg::LEN_W-1:0];
			bytes_left_d = hdr_len[mlrd_pkg::LEN_W-1:0];
			window_d = '0;
			fill_d = '0;
		end else begin
			window_d = shifted;
			fill_d = fill_inc;
		end

		res_push = beat_accept & eff_payload;
		result.payload_byte = data_byte;
		result.first_of_record = is_first;
		result.last_of_record = is_last;
		result.record_length = eff_len;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			fill_q <= '0;
			in_payload_q <= 1'b0;
			bytes_left_q <= '0;
			cur_len_q <= '0;
		end else if (beat_accept) begin
			window_q <= window_d;
			fill_q <= fill_d;
			in_payload_q <= in_payload_d;
			bytes_left_q <= bytes_left_d;
			cur_len_q <= cur_len_d;
		end
	end

`ifndef ASSERT_OFF
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= 4'd8)
		else $error("window fill out of range");
	a_left_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		in_payload_q |-> (bytes_left_q != '0) && (bytes_left_q <= cur_len_q))
		else $error("payload counter out of range");
	a_left_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!in_payload_q |-> (bytes_left_q == '0))
		else $error("payload counter not cleared while searching");
	a_window_clear: assert property (@(posedge clk) disable iff (!arst_n)
		in_payload_q |-> (fill_q == '0) && (window_q == '0))
		else $error("window not cleared during payload");
`endif

endmodule

// ----- sv/mlrd_out_fifo.sv -----
// ----------------------------------------------------------------------------
// mlrd_out_fifo
// Two-entry result buffer between the core and the output channel.
// ----------------------------------------------------------------------------
module mlrd_out_fifo (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  mlrd_pkg::result_t push_data,
	output logic full,
	output logic out_valid,
	input  logic out_ready,
	output mlrd_pkg::result_t out_data
);

	mlrd_pkg::result_t mem_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic pop;

	assign full = (count_q == 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign pop = out_valid & out_ready;
	assign out_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("push into full result buffer");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'd2)
		else $error("result buffer count out of range");
	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		((count_q == 2'd0) || (count_q == 2'd2)) |-> (wr_ptr_q == rd_ptr_q))
		else $error("result buffer pointers disagree with count");
`endif

endmodule

// ----- sv/magic_length_record_deframer.sv -----
// ----------------------------------------------------------------------------
// magic_length_record_deframer
// Output path: a payload beat is registered in the two-entry result buffer and offered from there.
// Throughput: one input beat per cycle, set by the window compare
// and payload counter; input stalls only while two payload beats wait in the buffer.
// Header bytes give no output beat.
// Reset: arst_n clears search state, counters and buffer; registers take defaults.
// ----------------------------------------------------------------------------
module magic_length_record_deframer (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [mlrd_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input  logic in_valid,
	output logic in_ready,
	input  logic [7:0] data_byte,
	input  logic file_start,
	output logic out_valid,
	input  logic out_ready,
	output logic [7:0] payload_byte,
	output logic first_of_record,
	output logic last_of_record,
	output logic [25:0] record_length
);

	logic [mlrd_pkg::MAGIC_W-1:0] magic_q;
	logic [mlrd_pkg::LEN_W-1:0] max_len_q;
	logic cfg_wr;
	logic beat_accept;
	logic res_push;
	logic fifo_full;
	mlrd_pkg::result_t core_res;
	mlrd_pkg::result_t out_res;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q <= mlrd_pkg::MAGIC_RESET;
			max_len_q <= mlrd_pkg::MAX_LEN_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				mlrd_pkg::REG_MAGIC_WORD: magic_q <= pwdata;
				mlrd_pkg::REG_MAX_LENGTH: max_len_q <= pwdata[mlrd_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			mlrd_pkg::REG_MAGIC_WORD: prdata = magic_q;
			mlrd_pkg::REG_MAX_LENGTH: prdata = {6'd0, max_len_q};
			default: prdata = '0;
		endcase
	end

	assign in_ready = ~fifo_full;
	assign beat_accept = in_valid & in_ready;

	mlrd_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.beat_accept(beat_accept),
		.data_byte(data_byte),
		.file_start(file_start),
		.magic_word(magic_q),
		.max_record_length(max_len_q),
		.res_push(res_push),
		.result(core_res)
	);

	mlrd_out_fifo u_out_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_push),
		.push_data(core_res),
		.full(fifo_full),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_res)
	);

	assign payload_byte = out_res.payload_byte;
	assign first_of_record = out_res.first_of_record;
	assign last_of_record = out_res.last_of_record;
	assign record_length = out_res.record_length;

`ifndef ASSERT_OFF
	a_len_floor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({6'd0, record_length} >= mlrd_pkg::MIN_RECORD_LENGTH))
		else $error("output beat with record length below minimum");
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !fifo_full)
		else $error("input ready while result buffer full");
`endif

endmodule
